@@ design/forward_difference_gradient_defines.svh @@
// ----------------------------------------------------------------------------
// forward_difference_gradient_defines.svh
// Assertion macros shared by the gradient block. Define ASSERT_OFF to drop
// all checks. Each macro expects clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef FORWARD_DIFFERENCE_GRADIENT_DEFINES_SVH
`define FORWARD_DIFFERENCE_GRADIENT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define FDG_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FDG_ASSERT_IMPLY(lbl, ante, cons, msg)
`define FDG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/fdg_pkg.sv @@
// ----------------------------------------------------------------------------
// fdg_pkg
// Types and constants shared by the forward difference gradient modules.
// ----------------------------------------------------------------------------
package fdg_pkg;

    // fixed field widths
    localparam int CFG_WIDTH_BITS = 11;
    localparam int ROW_BITS       = 16;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    // register reset values
    localparam logic [CFG_WIDTH_BITS-1:0] RESET_IMAGE_WIDTH  = 11'd1024;
    localparam logic [ROW_BITS-1:0]       RESET_IMAGE_HEIGHT = 16'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // live frame geometry
    typedef struct packed {
        logic [CFG_WIDTH_BITS-1:0] image_width;
        logic [ROW_BITS-1:0]       image_height;
    } fdg_cfg_t;

    // scan position of one request
    typedef struct packed {
        logic                first_row;
        logic                last_col;
        logic                last_row;
        logic [ROW_BITS-1:0] row;
    } fdg_pos_t;

    // which result of a request is being produced
    typedef enum logic [1:0] {
        SLOT_UPPER  = 2'd0,   // pixel of the row above
        SLOT_LEFT   = 2'd1,   // left neighbour in the last row
        SLOT_CORNER = 2'd2    // bottom right pixel of the frame
    } fdg_slot_t;

endpackage

@@ design/fdg_regs.sv @@
// ----------------------------------------------------------------------------
// fdg_regs
// APB register file holding image width and image height.
// ----------------------------------------------------------------------------
module fdg_regs
    import fdg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output fdg_cfg_t                 cfg
);

    logic [CFG_WIDTH_BITS-1:0] width_reg, width_next;
    logic [ROW_BITS-1:0]       height_reg, height_next;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register write decode
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  width_next  = pwdata[CFG_WIDTH_BITS-1:0];
                REG_IDX_HEIGHT: height_next = pwdata[ROW_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_IMAGE_WIDTH;
            height_reg <= RESET_IMAGE_HEIGHT;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_IDX_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
        endcase
    end

    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;

endmodule

@@ design/fdg_line_mem.sv @@
// ----------------------------------------------------------------------------
// fdg_line_mem
// One-line pixel buffer: one write port, two registered read ports.
// A read at the written address returns the old contents.
// ----------------------------------------------------------------------------
module fdg_line_mem
    import fdg_pkg::*;
#(
    parameter  int DEPTH     = 1024,
    parameter  int DATA_BITS = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [DATA_BITS-1:0] rd_data_a,
    output logic [DATA_BITS-1:0] rd_data_b
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_a_reg, rd_b_reg;

    // read first, then write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ design/fdg_scan.sv @@
// ----------------------------------------------------------------------------
// fdg_scan
// Raster position counters, clamped to the live frame geometry, and the
// line buffer addresses for the incoming pixel.
// ----------------------------------------------------------------------------
module fdg_scan
    import fdg_pkg::*;
#(
    parameter  int MAX_WIDTH = 1024,
    localparam int COL_BITS  = $clog2(MAX_WIDTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  fdg_cfg_t            cfg,
    input  logic                accept,
    output fdg_pos_t            pos,
    output logic [COL_BITS-1:0] col_idx,
    output logic [COL_BITS-1:0] col_right_idx
);

    localparam int WB = (COL_BITS + 1 > CFG_WIDTH_BITS) ? COL_BITS + 1 : CFG_WIDTH_BITS;
    localparam logic [WB-1:0] MAX_W = WB'(MAX_WIDTH);

    logic [WB-1:0]       w_ext, last_c_ext;
    logic [COL_BITS-1:0] last_c, c, col_reg, col_next;
    logic [ROW_BITS-1:0] last_r, r, row_reg, row_next;
    logic                last_col, last_row;

    // effective last column and last row
    always_comb
    begin
        w_ext = WB'(cfg.image_width);
        if (w_ext < WB'(2))
            last_c_ext = WB'(1);
        else if (w_ext > MAX_W)
            last_c_ext = MAX_W - WB'(1);
        else
            last_c_ext = w_ext - WB'(1);
        last_c = last_c_ext[COL_BITS-1:0];
        last_r = (cfg.image_height < ROW_BITS'(2)) ? ROW_BITS'(1)
                                                   : cfg.image_height - ROW_BITS'(1);
    end

    // clamped position
    assign c        = (col_reg >= last_c) ? last_c : col_reg;
    assign r        = (row_reg >= last_r) ? last_r : row_reg;
    assign last_col = (c == last_c);
    assign last_row = (r == last_r);

    assign pos.first_row = (r == '0);
    assign pos.last_col  = last_col;
    assign pos.last_row  = last_row;
    assign pos.row       = r;

    // line buffer addresses
    assign col_idx       = c;
    assign col_right_idx = (c == COL_BITS'(MAX_WIDTH - 1)) ? '0 : c + 1'b1;

    // advance on each request
    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r + 1'b1;
        end
        else
        begin
            col_next = c + 1'b1;
            row_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ design/fdg_emit.sv @@
// ----------------------------------------------------------------------------
// fdg_emit
// Difference stage: takes the line buffer read data, forms the gradients
// and sends the results of one request to the output register, one per
// cycle while that register is not stalled.
// ----------------------------------------------------------------------------
`include "forward_difference_gradient_defines.svh"

module fdg_emit
    import fdg_pkg::*;
#(
    parameter  int MAX_WIDTH  = 1024,
    parameter  int PIXEL_BITS = 16,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int GB         = PIXEL_BITS + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    output logic                         take_ok,
    input  fdg_pos_t                     pos,
    input  logic [COL_BITS-1:0]          col_in,
    input  logic signed [PIXEL_BITS-1:0] pixel_in,
    input  logic [PIXEL_BITS-1:0]        line_here,
    input  logic [PIXEL_BITS-1:0]        line_right,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic signed [GB-1:0]         res_grad_x,
    output logic signed [GB-1:0]         res_grad_y,
    output logic [COL_BITS-1:0]          res_col,
    output logic [ROW_BITS-1:0]          res_row,
    output logic                         res_last,
    output logic                         res_eof
);

    // stage registers
    logic                         s1_valid_reg, s1_valid_next;
    fdg_pos_t                     s1_pos_reg;
    logic [COL_BITS-1:0]          s1_col_reg;
    logic signed [PIXEL_BITS-1:0] s1_pix_reg;
    fdg_slot_t                    slot_reg, slot_next, last_slot;

    // history across requests
    logic signed [GB-1:0]         prev_gx_reg, prev_gy_reg;
    logic signed [PIXEL_BITS-1:0] prev_pix_reg;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic signed [GB-1:0]         out_gx_reg, out_gy_reg;
    logic [COL_BITS-1:0]          out_col_reg;
    logic [ROW_BITS-1:0]          out_row_reg;
    logic                         out_last_reg, out_eof_reg;

    logic signed [GB-1:0]         pix_ext, here_ext, right_ext, prev_pix_ext;
    logic signed [GB-1:0]         gy, gx_diff, gx, lgx;
    logic [1:0]                   res_count;
    logic                         out_load, slot_end, s1_done;
    logic signed [GB-1:0]         sel_gx, sel_gy;
    logic [COL_BITS-1:0]          sel_col;
    logic [ROW_BITS-1:0]          sel_row;
    logic                         sel_last, sel_eof;

    // sign extension
    assign pix_ext      = {s1_pix_reg[PIXEL_BITS-1], s1_pix_reg};
    assign here_ext     = {line_here[PIXEL_BITS-1], line_here};
    assign right_ext    = {line_right[PIXEL_BITS-1], line_right};
    assign prev_pix_ext = {prev_pix_reg[PIXEL_BITS-1], prev_pix_reg};

    // differences
    assign gy      = pix_ext - here_ext;
    assign gx_diff = right_ext - here_ext;
    assign gx      = s1_pos_reg.last_col ? prev_gx_reg : gx_diff;
    assign lgx     = pix_ext - prev_pix_ext;

    // results owed by the current request
    always_comb
    begin
        if (s1_pos_reg.first_row)
            res_count = 2'd0;
        else if (s1_pos_reg.last_row && (s1_col_reg != '0))
            res_count = s1_pos_reg.last_col ? 2'd3 : 2'd2;
        else
            res_count = 2'd1;
    end

    assign last_slot = fdg_slot_t'(res_count - 2'd1);
    assign slot_end  = (slot_reg == last_slot);
    assign out_load  = s1_valid_reg && (res_count != 2'd0) && (!out_valid_reg || res_ready);
    assign s1_done   = s1_valid_reg && ((res_count == 2'd0) || (out_load && slot_end));
    assign take_ok   = !s1_valid_reg || s1_done;

    // result select
    always_comb
    begin
        case (slot_reg)
            SLOT_LEFT:
            begin
                sel_gx   = lgx;
                sel_gy   = prev_gy_reg;
                sel_col  = s1_col_reg - 1'b1;
                sel_row  = s1_pos_reg.row;
                sel_last = (res_count == 2'd2);
                sel_eof  = 1'b0;
            end
            SLOT_CORNER:
            begin
                sel_gx   = lgx;
                sel_gy   = gy;
                sel_col  = s1_col_reg;
                sel_row  = s1_pos_reg.row;
                sel_last = 1'b1;
                sel_eof  = 1'b1;
            end
            default:
            begin
                sel_gx   = gx;
                sel_gy   = gy;
                sel_col  = s1_col_reg;
                sel_row  = s1_pos_reg.row - 1'b1;
                sel_last = (res_count == 2'd1);
                sel_eof  = 1'b0;
            end
        endcase
    end

    // stage control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (s1_done)
            s1_valid_next = 1'b0;

        slot_next = slot_reg;
        if (s1_done)
        begin
            slot_next = SLOT_UPPER;
        end
        else if (out_load)
        begin
            case (slot_reg)
                SLOT_UPPER: slot_next = SLOT_LEFT;
                SLOT_LEFT:  slot_next = SLOT_CORNER;
                default:    slot_next = SLOT_UPPER;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            slot_reg      <= SLOT_UPPER;
            out_valid_reg <= 1'b0;
            prev_gx_reg   <= '0;
            prev_gy_reg   <= '0;
            prev_pix_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            // history moves when a request retires
            if (s1_done)
            begin
                prev_pix_reg <= s1_pix_reg;
                if (!s1_pos_reg.first_row)
                begin
                    prev_gy_reg <= gy;
                    if (!s1_pos_reg.last_col)
                        prev_gx_reg <= gx_diff;
                end
            end
        end
    end

    // stage and output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pos_reg <= pos;
            s1_col_reg <= col_in;
            s1_pix_reg <= pixel_in;
        end
        if (out_load)
        begin
            out_gx_reg   <= sel_gx;
            out_gy_reg   <= sel_gy;
            out_col_reg  <= sel_col;
            out_row_reg  <= sel_row;
            out_last_reg <= sel_last;
            out_eof_reg  <= sel_eof;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_grad_x = out_gx_reg;
    assign res_grad_y = out_gy_reg;
    assign res_col    = out_col_reg;
    assign res_row    = out_row_reg;
    assign res_last   = out_last_reg;
    assign res_eof    = out_eof_reg;

    // checks
    `FDG_ASSERT_IMPLY(a_slot_range, s1_valid_reg && (res_count != 2'd0), slot_reg <= last_slot, "result slot beyond count")
    `FDG_ASSERT_IMPLY(a_no_take_busy, s1_valid_reg && !s1_done, !take, "request taken while stage busy")
    `FDG_ASSERT_IMPLY(a_eof_is_last, out_valid_reg && out_eof_reg, out_last_reg, "end of frame not on last result")
    `FDG_ASSERT_NEXT(a_slot_rewind, s1_done, slot_reg == SLOT_UPPER, "slot not rewound after request")

endmodule

@@ design/forward_difference_gradient.sv @@
// ----------------------------------------------------------------------------
// forward_difference_gradient
// Forward difference x/y gradient over a raster pixel stream, one line of
// pixels held in a buffer, edge column and edge row replicated.
//
//   port group   dir   handshake            payload
//   in           in    in_valid/in_ready    pixel
//   out          out   out_valid/out_ready  grad_x grad_y col row
//                                           last_of_run end_of_frame
//   apb          in    psel/penable/pready  paddr pwdata prdata
//
// One pixel request per cycle while in_ready is high. A last-row pixel past
// column 0 makes two results (three in the last column); the single output
// register drains one per cycle while out_ready is high, so in the last row
// in_ready waits for each pixel's last result. Reset clears counters, history
// and handshake state; the line buffer is not cleared. out_ready low stalls
// the output register, then the difference stage, then in_ready.
// ----------------------------------------------------------------------------
module forward_difference_gradient
    import fdg_pkg::*;
#(
    parameter  int MAX_WIDTH  = 1024,
    parameter  int PIXEL_BITS = 16,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int GB         = PIXEL_BITS + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready,
    // pixel input
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [PIXEL_BITS-1:0] pixel,
    // gradient output
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [GB-1:0]         grad_x,
    output logic signed [GB-1:0]         grad_y,
    output logic [COL_BITS-1:0]          col,
    output logic [ROW_BITS-1:0]          row,
    output logic                         last_of_run,
    output logic                         end_of_frame
);

    fdg_cfg_t              cfg;
    fdg_pos_t              pos;
    logic [COL_BITS-1:0]   col_idx, col_right_idx;
    logic [PIXEL_BITS-1:0] line_here, line_right;
    logic                  accept;

    assign accept = in_valid && in_ready;

    // configuration registers
    fdg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // raster position
    fdg_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .accept        (accept),
        .pos           (pos),
        .col_idx       (col_idx),
        .col_right_idx (col_right_idx)
    );

    // line buffer: read the row above at this column and the next, store pixel
    fdg_line_mem #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS)
    ) u_line_mem (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (col_idx),
        .wr_data   (pixel),
        .rd_en     (accept),
        .rd_addr_a (col_idx),
        .rd_addr_b (col_right_idx),
        .rd_data_a (line_here),
        .rd_data_b (line_right)
    );

    // difference stage and output register
    fdg_emit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (accept),
        .take_ok    (in_ready),
        .pos        (pos),
        .col_in     (col_idx),
        .pixel_in   (pixel),
        .line_here  (line_here),
        .line_right (line_right),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res_grad_x (grad_x),
        .res_grad_y (grad_y),
        .res_col    (col),
        .res_row    (row),
        .res_last   (last_of_run),
        .res_eof    (end_of_frame)
    );

endmodule
